>>> rtl/core/lfbs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the led frame buffer serializer
package lfbs_pkg;

	localparam int MODE_W = 2;
	localparam int IDX_W  = 7;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int CNT_W  = 7;

	localparam logic [MODE_W-1:0] MODE_SET       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TICK      = 2'd3;

	localparam logic [1:0] OP_WRITE     = 2'd0;
	localparam logic [1:0] OP_REJECT    = 2'd1;
	localparam logic [1:0] OP_CLEAR_ALL = 2'd2;
	localparam logic [1:0] OP_TICK      = 2'd3;

	localparam logic [CH_W-1:0] HDR_SYNC = 8'h06;
	localparam logic [CH_W-1:0] HDR_TYPE = 8'h85;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] addr;
		logic [PIX_W-1:0] data;
	} op_t;

endpackage

>>> rtl/core/lfbs_stream_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces
interface lfbs_req_if;
	import lfbs_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  led_index;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	modport source (output valid, mode, led_index, red, green, blue, input ready);
	modport sink (input valid, mode, led_index, red, green, blue, output ready);
endinterface

interface lfbs_rsp_if;
	import lfbs_pkg::*;
	logic            valid;
	logic            ready;
	logic            accepted;
	logic            byte_valid;
	logic [CH_W-1:0] frame_byte;
	logic            last_byte;
	modport source (output valid, accepted, byte_valid, frame_byte, last_byte, input ready);
	modport sink (input valid, accepted, byte_valid, frame_byte, last_byte, output ready);
endinterface

>>> rtl/core/led_frame_buffer_serializer.sv
`timescale 1ns / 1ps
// led frame buffer serializer top level
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        mode, led_index, red, green, blue
//   rsp      out  valid/ready        accepted, byte_valid, frame_byte, last_byte
//   cfg      in   cfg_we             cfg_wdata (led_count, clamped to MAX_LEDS)
//
// set, clear, clear all and header/checksum ticks load the response register when popped
// a colour byte tick first does a pixel store read, then loads the byte
// a two entry op queue takes requests while the response register is held
// reset clears the control state and the per-led valid bits, so the store reads black
// the store itself has no clearing pass
module led_frame_buffer_serializer #(
	parameter int MAX_LEDS = 85
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lfbs_pkg::CNT_W-1:0] cfg_wdata,
	lfbs_req_if.sink                   req,
	lfbs_rsp_if.source                 rsp
);
	import lfbs_pkg::*;

	logic [CNT_W-1:0] led_count_q;
	op_t              op;
	logic             op_valid;
	logic             op_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= '0;
		end else if (cfg_we) begin
			led_count_q <= (cfg_wdata > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : cfg_wdata;
		end
	end

	lfbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.led_count (led_count_q),
		.op        (op),
		.op_valid  (op_valid),
		.op_pop    (op_pop)
	);

	lfbs_back #(
		.MAX_LEDS(MAX_LEDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.op_valid  (op_valid),
		.op_pop    (op_pop),
		.led_count (led_count_q),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_count_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> led_count_q <= CNT_W'(MAX_LEDS))
		else $error("led count above limit");

	a_pop_needs_op: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> op_valid)
		else $error("op popped from empty queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> op_valid)
		else $error("accepted transaction missing from queue");

	a_reject_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.kind == OP_REJECT) |=> (rsp.valid && !rsp.accepted && !rsp.byte_valid))
		else $error("rejected op gave wrong response");

	a_clear_all_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.kind == OP_CLEAR_ALL) |=> (rsp.valid && rsp.accepted && !rsp.byte_valid))
		else $error("clear all gave wrong response");
`endif
endmodule

>>> rtl/core/lfbs_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module lfbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 85
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/core/lfbs_front.sv
`timescale 1ns / 1ps
// request decode and classification into a two entry op queue
module lfbs_front (
	input  logic                     clk,
	input  logic                     arst_n,
	lfbs_req_if.sink                 req,
	input  logic [lfbs_pkg::CNT_W-1:0] led_count,
	output lfbs_pkg::op_t            op,
	output logic                     op_valid,
	input  logic                     op_pop
);
	import lfbs_pkg::*;

	localparam int QDEPTH = 2;
	localparam int PW = $clog2(QDEPTH);

	op_t           slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;
	op_t           dec;
	logic          in_range;
	logic          push;

	assign in_range = req.led_index < led_count;
	assign req.ready = fill_q != (PW+1)'(QDEPTH);
	assign push = req.valid && req.ready;
	assign op_valid = fill_q != '0;
	assign op = slot_q[rd_ptr_q];

	always_comb begin
		dec.addr = req.led_index;
		dec.data = '0;
		case (req.mode)
			MODE_SET: begin
				dec.kind = in_range ? OP_WRITE : OP_REJECT;
				dec.data = {req.red, req.green, req.blue};
			end
			MODE_CLEAR: begin
				dec.kind = in_range ? OP_WRITE : OP_REJECT;
			end
			MODE_CLEAR_ALL: begin
				dec.kind = OP_CLEAR_ALL;
			end
			default: begin
				dec.kind = OP_TICK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (op_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !op_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && op_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/core/lfbs_back.sv
`timescale 1ns / 1ps
// op execution: pixel store updates and frame sequencing
module lfbs_back #(
	parameter int MAX_LEDS = 85
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lfbs_pkg::op_t              op,
	input  logic                       op_valid,
	output logic                       op_pop,
	input  logic [lfbs_pkg::CNT_W-1:0] led_count,
	lfbs_rsp_if.source                 rsp
);
	import lfbs_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_READ = 1'b1;

	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_TYPE = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	localparam logic [1:0] COMP_RED   = 2'd0;
	localparam logic [1:0] COMP_GREEN = 2'd1;
	localparam logic [1:0] COMP_BLUE  = 2'd2;

	logic                st_q;
	logic [1:0]          phase_q;
	logic [CNT_W-1:0]    led_q;
	logic [1:0]          comp_q;
	logic [CH_W-1:0]     csum_q;
	logic [MAX_LEDS-1:0] vld_q;
	logic                out_valid_q;
	logic                out_acc_q;
	logic                out_bv_q;
	logic [CH_W-1:0]     out_byte_q;
	logic                out_last_q;

	logic            data_left;
	logic [CH_W-1:0] len_byte;
	logic            ram_we;
	logic            ram_re;
	logic [PIX_W-1:0] ram_rdata;
	logic [CH_W-1:0] rd_byte;
	logic            load;
	logic            nxt_acc;
	logic            nxt_bv;
	logic [CH_W-1:0] nxt_byte;
	logic            nxt_last;

	assign op_pop = (st_q == ST_RUN) && op_valid && (!out_valid_q || rsp.ready);
	assign data_left = led_q < led_count;
	assign len_byte = {1'b0, led_count} + {led_count, 1'b0};
	assign ram_we = op_pop && (op.kind == OP_WRITE);
	assign ram_re = op_pop && (op.kind == OP_TICK) && (phase_q == PH_DATA) && data_left;

	lfbs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_LEDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (op.addr[AW-1:0]),
		.wdata (op.data),
		.re    (ram_re),
		.raddr (led_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (comp_q)
			COMP_RED:   rd_byte = ram_rdata[3*CH_W-1:2*CH_W];
			COMP_GREEN: rd_byte = ram_rdata[2*CH_W-1:CH_W];
			default:    rd_byte = ram_rdata[CH_W-1:0];
		endcase
		if (!vld_q[led_q[AW-1:0]]) begin
			rd_byte = '0;
		end
	end

	always_comb begin
		load     = 1'b0;
		nxt_acc  = 1'b1;
		nxt_bv   = 1'b0;
		nxt_byte = '0;
		nxt_last = 1'b0;
		if (st_q == ST_READ) begin
			load     = 1'b1;
			nxt_bv   = 1'b1;
			nxt_byte = rd_byte;
		end else if (op_pop) begin
			load = 1'b1;
			case (op.kind)
				OP_REJECT: nxt_acc = 1'b0;
				OP_TICK: begin
					nxt_bv = 1'b1;
					case (phase_q)
						PH_SYNC: nxt_byte = HDR_SYNC;
						PH_TYPE: nxt_byte = HDR_TYPE;
						PH_LEN:  nxt_byte = len_byte;
						default: begin
							if (data_left) begin
								load = 1'b0;
							end else begin
								nxt_byte = csum_q;
								nxt_last = 1'b1;
							end
						end
					endcase
				end
				default: nxt_acc = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RUN;
			phase_q     <= PH_SYNC;
			led_q       <= '0;
			comp_q      <= COMP_RED;
			csum_q      <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (st_q == ST_READ) begin
				st_q   <= ST_RUN;
				csum_q <= csum_q ^ rd_byte;
				if (comp_q == COMP_BLUE) begin
					comp_q <= COMP_RED;
					led_q  <= led_q + 1'b1;
				end else begin
					comp_q <= comp_q + 1'b1;
				end
			end else if (op_pop) begin
				case (op.kind)
					OP_WRITE:     vld_q[op.addr[AW-1:0]] <= 1'b1;
					OP_CLEAR_ALL: vld_q <= '0;
					OP_TICK: begin
						case (phase_q)
							PH_SYNC: phase_q <= PH_TYPE;
							PH_TYPE: phase_q <= PH_LEN;
							PH_LEN: begin
								phase_q <= PH_DATA;
								csum_q  <= len_byte;
								led_q   <= '0;
								comp_q  <= COMP_RED;
							end
							default: begin
								if (data_left) begin
									st_q <= ST_READ;
								end else begin
									phase_q <= PH_SYNC;
									csum_q  <= '0;
								end
							end
						endcase
					end
					default: phase_q <= phase_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_acc_q  <= nxt_acc;
			out_bv_q   <= nxt_bv;
			out_byte_q <= nxt_byte;
			out_last_q <= nxt_last;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.accepted   = out_acc_q;
	assign rsp.byte_valid = out_bv_q;
	assign rsp.frame_byte = out_byte_q;
	assign rsp.last_byte  = out_last_q;
endmodule
